>>> rtl/chaosnet_interface_registers_unit_defines.svh
// assertion macros for the network interface register unit
`ifndef CHAOSNET_INTERFACE_REGISTERS_UNIT_DEFINES_SVH
`define CHAOSNET_INTERFACE_REGISTERS_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define CHNI_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define CHNI_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/chni_pkg.sv
// shared types, constants and helpers of the network interface register unit
package chni_pkg;

	localparam int BUF_WORDS = 4096;
	localparam int AW = $clog2(BUF_WORDS);
	localparam int CW = AW + 1;

	localparam logic [15:0] OWN_ADDR_RST = 16'o401;
	localparam logic [15:0] EMPTY_BITS = 16'o7777;
	localparam logic [CW-1:0] DISCARD_BUSY = {CW{1'b1}};
	localparam logic [CW-1:0] DISCARD_LONG = {{(CW-1){1'b1}}, 1'b0};

	// csr bit positions
	localparam int B_LOOP = 1;
	localparam int B_RX_CLR = 3;
	localparam int B_RX_EN = 4;
	localparam int B_TX_EN = 5;
	localparam int B_TX_ABORT = 6;
	localparam int B_TX_DONE = 7;
	localparam int B_TX_CLR = 8;
	localparam int B_LOST_LO = 9;
	localparam int B_RESET = 13;
	localparam int B_RX_DONE = 15;
	localparam logic [15:0] CSR_KEEP = 16'hDE88;

	typedef enum logic [3:0] {
		OP_RD_CSR = 4'd0,
		OP_WR_CSR = 4'd1,
		OP_WR_TX = 4'd2,
		OP_RD_RX = 4'd3,
		OP_RD_BITS = 4'd4,
		OP_RD_ADDR = 4'd5,
		OP_TRANSMIT = 4'd6,
		OP_LINK_RX = 4'd7,
		OP_LINK_PULL = 4'd8
	} op_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_EXEC,
		S_TX_CHK,
		S_TX_DEC,
		S_COPY,
		S_COPY_END,
		S_TX_END,
		S_LINK_CHK,
		S_RESP
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic exec;
		logic tx_chk;
		logic tx_dec;
		logic copy;
		logic copy_end;
		logic tx_end;
		logic link_chk;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic is_tx;
		logic link_chk;
		logic match;
		logic copy_last;
	} stat_t;

	// ones'-complement add of two words
	function automatic logic [15:0] ones_add(logic [15:0] a, logic [15:0] b);
		logic [16:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[15:0] + {15'd0, s[16]};
	endfunction

	// bit count minus one of a packet of n words
	function automatic logic [15:0] bit_len(logic [CW-1:0] n);
		logic [CW+3:0] t;
		t = {n, 4'b0000} - (CW+4)'(1);
		return t[15:0];
	endfunction

endpackage

>>> rtl/chni_ram.sv
// generic single write port memory with registered read
module chni_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

>>> rtl/chni_ctrl.sv
// sequencing state machine of the network interface register unit
module chni_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  chni_pkg::stat_t st,
	output chni_pkg::cmd_t cmd,
	output logic           busy,
	output logic           result_valid
);
	import chni_pkg::*;

	state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd = '0;
		busy = 1'b1;
		result_valid = 1'b0;
		unique case (state_q)
			S_IDLE, S_RESP: begin
				busy = 1'b0;
				result_valid = (state_q == S_RESP);
				cmd.load = start;
				state_d = start ? S_EXEC : S_IDLE;
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
				if (st.is_tx) begin
					state_d = S_TX_CHK;
				end else if (st.link_chk) begin
					state_d = S_LINK_CHK;
				end else begin
					state_d = S_RESP;
				end
			end
			S_TX_CHK: begin
				cmd.tx_chk = 1'b1;
				state_d = S_TX_DEC;
			end
			S_TX_DEC: begin
				cmd.tx_dec = 1'b1;
				state_d = st.match ? S_COPY : S_TX_END;
			end
			S_COPY: begin
				cmd.copy = 1'b1;
				state_d = st.copy_last ? S_COPY_END : S_COPY;
			end
			S_COPY_END: begin
				cmd.copy_end = 1'b1;
				state_d = S_TX_END;
			end
			S_TX_END: begin
				cmd.tx_end = 1'b1;
				state_d = S_RESP;
			end
			S_LINK_CHK: begin
				cmd.link_chk = 1'b1;
				state_d = S_RESP;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end
endmodule

>>> rtl/chni_dpath.sv
// registers, buffers and request execution of the network interface register unit
module chni_dpath (
	input  logic           clk,
	input  logic           arst_n,
	input  chni_pkg::cmd_t cmd,
	output chni_pkg::stat_t st,
	input  logic [3:0]     op,
	input  logic [15:0]    write_data,
	input  logic           link_last,
	input  logic           cfg_wr,
	input  logic [15:0]    cfg_data,
	output logic [15:0]    read_data,
	output logic           tx_valid,
	output logic           tx_last,
	output logic           interrupt
);
	import chni_pkg::*;

	typedef enum logic [1:0] {SRC_REG, SRC_TX, SRC_RX} src_t;

	// latched request
	op_t         op_q;
	logic [15:0] wd_q;
	logic        last_q;

	// interface state
	logic [15:0]   own_q;
	logic [15:0]   csr_q, csr_d;
	logic [CW-1:0] fill_q, fill_d;
	logic [15:0]   sum_q, sum_d;
	logic [CW-1:0] out_len_q, out_len_d;
	logic [CW-1:0] out_idx_q, out_idx_d;
	logic [CW-1:0] rri_q, rri_d;
	logic [CW-1:0] rxlen_q, rxlen_d;
	logic [CW-1:0] arr_q, arr_d;
	logic          empty_q, empty_d;
	logic [15:0]   bc_q, bc_d;
	logic [3:0]    lost_q, lost_d;
	logic [CW-1:0] len_q, len_d;
	logic [CW-1:0] cidx_q, cidx_d;

	// result registers
	logic [15:0] rd_q, rd_d;
	logic        tv_q, tv_d;
	logic        tl_q, tl_d;
	logic        irq_q, irq_d;
	src_t        src_q, src_d;

	// buffer ports
	logic          tx_we, rx_we;
	logic [AW-1:0] tx_waddr, tx_raddr, rx_waddr, rx_raddr;
	logic [15:0]   tx_wdata, rx_wdata, tx_rdata, rx_rdata;

	chni_ram #(.WIDTH(16), .DEPTH(BUF_WORDS)) u_tx_ram (
		.clk(clk), .we(tx_we), .waddr(tx_waddr), .wdata(tx_wdata),
		.raddr(tx_raddr), .rdata(tx_rdata)
	);

	chni_ram #(.WIDTH(16), .DEPTH(BUF_WORDS)) u_rx_ram (
		.clk(clk), .we(rx_we), .waddr(rx_waddr), .wdata(rx_wdata),
		.raddr(rx_raddr), .rdata(rx_rdata)
	);

	// request latch
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= op_t'(op);
			wd_q <= write_data;
			last_q <= link_last;
		end
	end

	// request execution and buffer sequencing
	always_comb begin
		logic [15:0]   c;
		logic [CW-1:0] a1;
		logic [CW-1:0] t;
		csr_d = csr_q; fill_d = fill_q; sum_d = sum_q;
		out_len_d = out_len_q; out_idx_d = out_idx_q;
		rri_d = rri_q; rxlen_d = rxlen_q; arr_d = arr_q; empty_d = empty_q;
		bc_d = bc_q; lost_d = lost_q; len_d = len_q; cidx_d = cidx_q;
		rd_d = rd_q; tv_d = tv_q; tl_d = tl_q; irq_d = irq_q; src_d = src_q;
		tx_we = 1'b0; tx_waddr = fill_q[AW-1:0]; tx_wdata = wd_q;
		tx_raddr = out_idx_q[AW-1:0];
		rx_we = 1'b0; rx_waddr = arr_q[AW-1:0]; rx_wdata = wd_q;
		rx_raddr = rri_q[AW-1:0];
		st = '0;
		c = '0; a1 = '0; t = '0;

		if (cmd.exec) begin
			rd_d = '0; tv_d = 1'b0; tl_d = 1'b0; irq_d = 1'b0; src_d = SRC_REG;
			unique case (op_q)
				OP_RD_CSR: begin
					rd_d = csr_q | {3'b000, lost_q, 9'd0};
				end
				OP_WR_CSR: begin
					c = (csr_q & CSR_KEEP) | (wd_q & ~CSR_KEEP);
					if (c[B_RESET]) begin
						rxlen_d = '0; fill_d = '0; sum_d = '0; lost_d = '0;
						bc_d = '0; rri_d = '0; arr_d = '0;
						out_len_d = '0; out_idx_d = '0;
						c[B_RESET] = 1'b0; c[B_RX_DONE] = 1'b0; c[B_TX_DONE] = 1'b1;
					end
					if (wd_q[B_RX_CLR]) begin
						c[B_RX_DONE] = 1'b0;
						lost_d = '0; bc_d = '0; rri_d = '0; rxlen_d = '0;
					end
					if (wd_q[B_TX_CLR] || wd_q[B_TX_DONE]) begin
						c[B_TX_ABORT] = 1'b0; c[B_TX_DONE] = 1'b1;
						fill_d = '0; sum_d = '0;
					end
					if (c[B_RX_EN]) begin
						if (empty_q) begin
							rri_d = '0; rxlen_d = '0;
						end
						if (rxlen_d != '0) begin
							rri_d = '0;
							bc_d = bit_len(rxlen_d);
							c[B_RX_DONE] = 1'b1;
							irq_d = 1'b1;
						end
					end
					if (c[B_TX_EN]) begin
						c[B_TX_DONE] = 1'b1;
					end
					csr_d = c;
				end
				OP_WR_TX: begin
					if (fill_q < CW'(BUF_WORDS - 2)) begin
						tx_we = 1'b1;
						fill_d = fill_q + CW'(1);
						sum_d = ones_add(sum_q, wd_q);
					end
					csr_d[B_TX_DONE] = 1'b0;
				end
				OP_RD_RX: begin
					if (rri_q < rxlen_q) begin
						src_d = SRC_RX;
						rri_d = rri_q + CW'(1);
						if (rri_d == rxlen_q) begin
							empty_d = 1'b1;
						end
					end else begin
						csr_d[B_RX_DONE] = 1'b0;
						rxlen_d = '0;
					end
				end
				OP_RD_BITS: begin
					rd_d = (rxlen_q != '0) ? bc_q : EMPTY_BITS;
				end
				OP_RD_ADDR: begin
					rd_d = own_q;
				end
				OP_TRANSMIT: begin
					// source word goes after the host words
					tx_we = 1'b1;
					tx_wdata = own_q;
					sum_d = ones_add(sum_q, own_q);
					st.is_tx = 1'b1;
				end
				OP_LINK_RX: begin
					if (arr_q == DISCARD_BUSY || arr_q == DISCARD_LONG) begin
						if (last_q) begin
							if (arr_q == DISCARD_BUSY && lost_q != 4'hF) begin
								lost_d = lost_q + 4'd1;
							end
							arr_d = '0;
						end
					end else if (!empty_q && csr_q[B_RX_DONE]) begin
						if (last_q) begin
							if (lost_q != 4'hF) begin
								lost_d = lost_q + 4'd1;
							end
							arr_d = '0;
						end else begin
							arr_d = DISCARD_BUSY;
						end
					end else if (arr_q >= CW'(BUF_WORDS)) begin
						arr_d = last_q ? '0 : DISCARD_LONG;
					end else begin
						rx_we = 1'b1;
						a1 = arr_q + CW'(1);
						arr_d = last_q ? '0 : a1;
						if (last_q) begin
							if (a1 >= CW'(3)) begin
								// destination word is read back next cycle
								len_d = a1;
								t = a1 - CW'(3);
								rx_raddr = t[AW-1:0];
								st.link_chk = 1'b1;
							end else begin
								rxlen_d = '0; empty_d = 1'b1;
							end
						end
					end
				end
				OP_LINK_PULL: begin
					if (out_idx_q < out_len_q) begin
						src_d = SRC_TX;
						tv_d = 1'b1;
						a1 = out_idx_q + CW'(1);
						tl_d = (a1 == out_len_q);
						if (a1 >= out_len_q) begin
							out_idx_d = '0; out_len_d = '0;
						end else begin
							out_idx_d = a1;
						end
					end
				end
				default: begin
				end
			endcase
		end

		// checksum word and destination lookup
		if (cmd.tx_chk) begin
			t = fill_q + CW'(1);
			tx_we = 1'b1;
			tx_waddr = t[AW-1:0];
			tx_wdata = ~{sum_q[7:0], sum_q[15:8]};
			t = fill_q - CW'(1);
			tx_raddr = t[AW-1:0];
			len_d = fill_q + CW'(2);
		end

		// loopback or self-addressed decision
		if (cmd.tx_dec) begin
			st.match = csr_q[B_LOOP] || (tx_rdata == own_q);
			cidx_d = '0;
		end

		// copy transmit buffer into receive buffer, one word a cycle
		if (cmd.copy || cmd.copy_end) begin
			t = cidx_q - CW'(1);
			rx_waddr = t[AW-1:0];
			rx_wdata = tx_rdata;
		end
		if (cmd.copy) begin
			tx_raddr = cidx_q[AW-1:0];
			rx_we = (cidx_q != '0);
			cidx_d = cidx_q + CW'(1);
			st.copy_last = (cidx_q == len_q - CW'(1));
		end
		if (cmd.copy_end) begin
			rx_we = 1'b1;
			rxlen_d = len_q; empty_d = 1'b0; rri_d = '0;
			bc_d = bit_len(len_q);
			csr_d[B_RX_DONE] = 1'b1;
			if (csr_q[B_RX_EN]) begin
				irq_d = 1'b1;
			end
		end

		// transmit wrap-up
		if (cmd.tx_end) begin
			if (!csr_q[B_LOOP]) begin
				out_len_d = len_q; out_idx_d = '0;
			end
			fill_d = '0; sum_d = '0;
			csr_d[B_TX_DONE] = 1'b1;
			if (csr_q[B_TX_EN]) begin
				irq_d = 1'b1;
			end
		end

		// link packet destination decision
		if (cmd.link_chk) begin
			if (rx_rdata == own_q) begin
				rxlen_d = len_q; empty_d = 1'b0; rri_d = '0;
				bc_d = bit_len(len_q);
				csr_d[B_RX_DONE] = 1'b1;
				if (csr_q[B_RX_EN]) begin
					irq_d = 1'b1;
				end
			end else begin
				rxlen_d = '0; empty_d = 1'b1;
			end
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_q <= OWN_ADDR_RST;
			csr_q <= '0; fill_q <= '0; sum_q <= '0;
			out_len_q <= '0; out_idx_q <= '0;
			rri_q <= '0; rxlen_q <= '0; arr_q <= '0; empty_q <= 1'b1;
			bc_q <= '0; lost_q <= '0;
			src_q <= SRC_REG;
		end else begin
			if (cfg_wr) begin
				own_q <= cfg_data;
			end
			csr_q <= csr_d; fill_q <= fill_d; sum_q <= sum_d;
			out_len_q <= out_len_d; out_idx_q <= out_idx_d;
			rri_q <= rri_d; rxlen_q <= rxlen_d; arr_q <= arr_d; empty_q <= empty_d;
			bc_q <= bc_d; lost_q <= lost_d;
			src_q <= src_d;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		len_q <= len_d; cidx_q <= cidx_d;
		rd_q <= rd_d; tv_q <= tv_d; tl_q <= tl_d; irq_q <= irq_d;
	end

	// result selection
	always_comb begin
		unique case (src_q)
			SRC_TX: read_data = tx_rdata;
			SRC_RX: read_data = rx_rdata;
			default: read_data = rd_q;
		endcase
	end
	assign tx_valid = tv_q;
	assign tx_last = tl_q;
	assign interrupt = irq_q;
endmodule

>>> rtl/chaosnet_interface_registers_unit.sv
// Network interface register unit: command requests against CSR and packet buffers.
// Register reads, writes and link words pass from the execute state to the response state,
// which strobes the result; a link word ending a packet of three or more words also passes the destination check state.
// Transmit passes the checksum, decision and wrap-up states, with a word-by-word copy into
// the receive buffer when looped back or self-addressed. Results cannot be stalled.
// Reset clears all control state at once; buffers hold no reset and need no clearing pass.
module chaosnet_interface_registers_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [3:0]  op,
	input  logic [15:0] write_data,
	input  logic        link_last,
	output logic        result_valid,
	output logic [15:0] read_data,
	output logic        tx_valid,
	output logic        tx_last,
	output logic        interrupt,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data
);
	import chni_pkg::*;

	`include "chaosnet_interface_registers_unit_defines.svh"

	cmd_t  cmd;
	stat_t st;

	assign cfg_ready = 1'b1;

	chni_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .st(st), .cmd(cmd),
		.busy(busy), .result_valid(result_valid)
	);

	chni_dpath u_dpath (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .st(st),
		.op(op), .write_data(write_data), .link_last(link_last),
		.cfg_wr(cfg_valid && cfg_ready), .cfg_data(cfg_data),
		.read_data(read_data), .tx_valid(tx_valid), .tx_last(tx_last),
		.interrupt(interrupt)
	);

	// checks
	`CHNI_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted request did not go busy")
	`CHNI_ASSERT_IMPL(a_last_valid, tx_last, tx_valid, "tx_last without tx_valid")
	`CHNI_ASSERT_IMPL(a_tx_strobe, result_valid, !busy, "result strobe while busy")
	`CHNI_ASSERT_NEXT(a_one_result, result_valid, !result_valid, "result strobe held two cycles")
endmodule

>>> dv/tb.sv
// testbench for the network interface register unit: predictor-checked request stream
`timescale 1ns / 100ps

module tb;
	import chni_pkg::*;

	localparam int CYCLE_LIMIT = 3000000;
	localparam int RANDOM_ITEMS = 1700;
	localparam int MAX_REPORTS = 10;
	localparam int SETTLE_CYCLES = 20;
	localparam logic [3:0] OP_SPARE_LO = 4'd9;
	localparam logic [3:0] OP_SPARE_HI = 4'd15;
	localparam logic [15:0] NO_BITS = 16'o7777;
	localparam logic [15:0] ADDR_AT_RESET = 16'o401;
	localparam logic [15:0] V_LOOP = 16'(1 << B_LOOP);
	localparam logic [15:0] V_RX_CLR = 16'(1 << B_RX_CLR);
	localparam logic [15:0] V_RX_EN = 16'(1 << B_RX_EN);
	localparam logic [15:0] V_TX_EN = 16'(1 << B_TX_EN);
	localparam logic [15:0] V_TX_CLR = 16'(1 << B_TX_CLR);
	localparam logic [15:0] V_RESET = 16'(1 << B_RESET);

	typedef struct packed {
		logic [15:0] rd;
		logic tv;
		logic tl;
		logic irq;
	} resp_t;

	typedef struct {
		logic [3:0] opc;
		logic [15:0] wd;
		logic lst;
		logic known;
		resp_t want;
	} row_t;

	logic clk, arst_n, start, busy, link_last, result_valid;
	logic [3:0] op;
	logic [15:0] write_data, read_data, cfg_data;
	logic tx_valid, tx_last, interrupt, cfg_valid, cfg_ready;

	chaosnet_interface_registers_unit DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .op(op),
		.write_data(write_data), .link_last(link_last), .result_valid(result_valid),
		.read_data(read_data), .tx_valid(tx_valid), .tx_last(tx_last),
		.interrupt(interrupt), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	// shadow state of the interface
	logic [15:0] own_addr, csr, tx_sum, bit_cnt;
	logic [15:0] tx_mem [BUF_WORDS];
	logic [15:0] rx_mem [BUF_WORDS];
	int unsigned tx_fill, out_len, out_idx, rd_idx, rx_len, arrive;
	logic rx_empty;
	logic [3:0] lost;

	resp_t expected_responses [$];
	int errors, reports, items, responses, sent_packets;
	int unsigned cycles;
	int burst_left;

	function automatic logic [15:0] csum_add(logic [15:0] a, logic [15:0] b);
		logic [16:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s[16])
			s = s - 17'h0ffff;
		return s[15:0];
	endfunction

	function automatic logic post_packet();
		rd_idx = 0;
		bit_cnt = 16'(rx_len * 16 - 1);
		if (rx_len > 0) begin
			csr[B_RX_DONE] = 1'b1;
			return csr[B_RX_EN];
		end
		return 1'b0;
	endfunction

	function automatic logic csr_write(logic [15:0] v);
		logic irq;
		irq = 1'b0;
		csr = (csr & CSR_KEEP) | (v & ~CSR_KEEP);
		if (csr[B_RESET]) begin
			rx_len = 0; tx_fill = 0; tx_sum = 0; lost = 0; bit_cnt = 0;
			rd_idx = 0; arrive = 0; out_len = 0; out_idx = 0;
			csr[B_RESET] = 1'b0;
			csr[B_RX_DONE] = 1'b0;
			csr[B_TX_DONE] = 1'b1;
		end
		if (v[B_RX_CLR]) begin
			csr[B_RX_DONE] = 1'b0;
			lost = 0; bit_cnt = 0; rd_idx = 0; rx_len = 0;
		end
		if (v[B_TX_CLR] || v[B_TX_DONE]) begin
			csr[B_TX_ABORT] = 1'b0;
			csr[B_TX_DONE] = 1'b1;
			tx_fill = 0; tx_sum = 0;
		end
		if (csr[B_RX_EN]) begin
			if (rx_empty) begin
				rd_idx = 0;
				rx_len = 0;
			end
			if (rx_len > 0)
				irq = post_packet();
		end
		if (csr[B_TX_EN])
			csr[B_TX_DONE] = 1'b1;
		return irq;
	endfunction

	function automatic logic send_packet();
		int unsigned n;
		logic [15:0] s;
		logic irq;
		irq = 1'b0;
		n = tx_fill;
		tx_mem[n] = own_addr;
		s = csum_add(tx_sum, own_addr);
		n++;
		tx_mem[n] = ~{s[7:0], s[15:8]};
		n++;
		// destination word wraps around the store for a short packet
		if (csr[B_LOOP] || tx_mem[(n + BUF_WORDS - 3) % BUF_WORDS] == own_addr) begin
			for (int i = 0; i < n; i++)
				rx_mem[i] = tx_mem[i];
			rx_len = n;
			rx_empty = 1'b0;
			irq = post_packet();
		end
		if (!csr[B_LOOP]) begin
			out_len = n;
			out_idx = 0;
		end
		tx_fill = 0; tx_sum = 0;
		csr[B_TX_DONE] = 1'b1;
		if (csr[B_TX_EN])
			irq = 1'b1;
		return irq;
	endfunction

	function automatic logic take_link_word(logic [15:0] w, logic lst);
		int unsigned n;
		if (arrive == DISCARD_BUSY || arrive == DISCARD_LONG) begin
			if (lst) begin
				if (arrive == DISCARD_BUSY && lost < 15)
					lost++;
				arrive = 0;
			end
			return 1'b0;
		end
		if (!rx_empty && csr[B_RX_DONE]) begin
			if (lst) begin
				if (lost < 15)
					lost++;
				arrive = 0;
			end else begin
				arrive = DISCARD_BUSY;
			end
			return 1'b0;
		end
		if (arrive >= BUF_WORDS) begin
			arrive = lst ? 0 : DISCARD_LONG;
			return 1'b0;
		end
		rx_mem[arrive] = w;
		arrive++;
		if (!lst)
			return 1'b0;
		n = arrive;
		arrive = 0;
		if (n >= 3 && rx_mem[n-3] == own_addr) begin
			rx_len = n;
			rx_empty = 1'b0;
			return post_packet();
		end
		rx_len = 0;
		rx_empty = 1'b1;
		return 1'b0;
	endfunction

	// expected response of one request, advancing the shadow state
	function automatic resp_t predict_response(logic [3:0] opc, logic [15:0] wd, logic lst);
		resp_t r;
		r = '0;
		case (opc)
			OP_RD_CSR: r.rd = csr | ({12'd0, lost} << B_LOST_LO);
			OP_WR_CSR: r.irq = csr_write(wd);
			OP_WR_TX: begin
				if (tx_fill < BUF_WORDS - 2) begin
					tx_mem[tx_fill] = wd;
					tx_fill++;
					tx_sum = csum_add(tx_sum, wd);
				end
				csr[B_TX_DONE] = 1'b0;
			end
			OP_RD_RX: begin
				if (rd_idx < rx_len) begin
					r.rd = rx_mem[rd_idx];
					rd_idx++;
					if (rd_idx == rx_len)
						rx_empty = 1'b1;
				end else begin
					csr[B_RX_DONE] = 1'b0;
					rx_len = 0;
				end
			end
			OP_RD_BITS: r.rd = (rx_len > 0) ? bit_cnt : NO_BITS;
			OP_RD_ADDR: r.rd = own_addr;
			OP_TRANSMIT: r.irq = send_packet();
			OP_LINK_RX: r.irq = take_link_word(wd, lst);
			OP_LINK_PULL: begin
				if (out_idx < out_len) begin
					r.rd = tx_mem[out_idx];
					r.tv = 1'b1;
					r.tl = (out_idx + 1 == out_len);
					out_idx++;
					if (out_idx >= out_len) begin
						out_idx = 0;
						out_len = 0;
					end
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	// clock and cycle limit
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d responses pending", cycles,
				expected_responses.size());
			$display("tb failed");
			$finish;
		end
	end

	// response checker
	always @(posedge clk) begin
		resp_t e;
		if (arst_n && result_valid) begin
			responses++;
			if (expected_responses.size() == 0) begin
				errors++;
				if (reports < MAX_REPORTS) begin
					reports++;
					$display("unexpected response rd=%h at cycle %0d", read_data, cycles);
				end
			end else begin
				e = expected_responses.pop_front();
				if (e.rd !== read_data || e.tv !== tx_valid || e.tl !== tx_last ||
						e.irq !== interrupt) begin
					errors++;
					if (reports < MAX_REPORTS) begin
						reports++;
						$display("mismatch cycle %0d: want rd=%h tv=%b tl=%b irq=%b, got rd=%h tv=%b tl=%b irq=%b",
							cycles, e.rd, e.tv, e.tl, e.irq, read_data, tx_valid, tx_last,
							interrupt);
					end
				end
			end
		end
	end

	// one request; entered and left at a falling edge
	task automatic issue(logic [3:0] opc, logic [15:0] wd, logic lst, logic known = 1'b0,
			resp_t want = '0);
		resp_t r;
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 6);
			if (gap > 0) begin
				start <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		start <= 1'b1;
		op <= opc;
		write_data <= wd;
		link_last <= lst;
		forever begin
			@(posedge clk);
			if (!busy)
				break;
		end
		r = predict_response(opc, wd, lst);
		expected_responses.push_back(known ? want : r);
		items++;
		@(negedge clk);
	endtask

	task automatic drain();
		start <= 1'b0;
		while (expected_responses.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
		while (busy)
			@(negedge clk);
	endtask

	task automatic write_station_address(logic [15:0] v);
		drain();
		cfg_valid <= 1'b1;
		cfg_data <= v;
		forever begin
			@(posedge clk);
			if (cfg_ready)
				break;
		end
		own_addr = v;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// transmit, padding an empty packet unless looped back
	task automatic send();
		if (tx_fill == 0 && !csr[B_LOOP])
			issue(OP_WR_TX, 16'($urandom), $urandom_range(0, 1));
		issue(OP_TRANSMIT, 16'($urandom), $urandom_range(0, 1));
		sent_packets++;
	endtask

	task automatic tx_sequence();
		int n;
		n = $urandom_range(0, 8);
		for (int i = 0; i < n; i++)
			issue(OP_WR_TX, (i == n - 1 && $urandom_range(0, 1)) ? own_addr : 16'($urandom),
				$urandom_range(0, 1));
		send();
		n = n + 2 + $urandom_range(0, 2) - $urandom_range(0, 3);
		for (int i = 0; i < n; i++)
			issue(OP_LINK_PULL, 16'($urandom), $urandom_range(0, 1));
	endtask

	task automatic link_sequence();
		int n;
		n = $urandom_range(1, 8);
		for (int i = 0; i < n; i++)
			issue(OP_LINK_RX, (i == n - 3 && $urandom_range(0, 3) != 0) ? own_addr
				: 16'($urandom), (i == n - 1) ? ($urandom_range(0, 7) != 0) : 1'b0);
	endtask

	task automatic drain_sequence();
		int n;
		n = rx_len + $urandom_range(0, 1) - $urandom_range(0, 2);
		issue(OP_RD_BITS, 16'($urandom), $urandom_range(0, 1));
		for (int i = 0; i < n; i++)
			issue(OP_RD_RX, 16'($urandom), $urandom_range(0, 1));
	endtask

	task automatic csr_sequence();
		logic [15:0] v;
		v = 16'($urandom);
		if ($urandom_range(0, 15) != 0)
			v = v & ~V_RESET;
		if ($urandom_range(0, 5) != 0)
			v = v & ~V_RX_CLR;
		issue(OP_WR_CSR, v, $urandom_range(0, 1));
		issue(OP_RD_CSR, 16'($urandom), $urandom_range(0, 1));
	endtask

	task automatic random_chunk(int count);
		int stop_at, k;
		logic [3:0] opc;
		stop_at = items + count;
		while (items < stop_at) begin
			k = $urandom_range(0, 99);
			if (k < 30)
				tx_sequence();
			else if (k < 55)
				link_sequence();
			else if (k < 72)
				drain_sequence();
			else if (k < 85)
				csr_sequence();
			else begin
				// transmit goes through send so that an empty packet gets padded
				opc = 4'($urandom);
				if (opc == OP_TRANSMIT)
					send();
				else
					issue(opc, 16'($urandom), $urandom_range(0, 1));
			end
		end
	endtask

	// directed requests; known responses typed in for the leading rows, the rest predicted
	row_t rows [$];

	initial begin
		row_t rw;
		cycles = 0; errors = 0; reports = 0; items = 0; responses = 0;
		sent_packets = 0; burst_left = 0;
		start = 1'b0; op = OP_RD_CSR; write_data = '0; link_last = 1'b0;
		cfg_valid = 1'b0; cfg_data = '0;
		own_addr = ADDR_AT_RESET; csr = '0; tx_sum = '0; bit_cnt = '0;
		tx_fill = 0; out_len = 0; out_idx = 0; rd_idx = 0; rx_len = 0; arrive = 0;
		rx_empty = 1'b1; lost = '0;
		arst_n = 1'b0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		rows = '{
			'{OP_RD_CSR, 16'hffff, 1'b1, 1'b1, '0},
			'{OP_RD_ADDR, 16'h0000, 1'b0, 1'b1, '{ADDR_AT_RESET, 1'b0, 1'b0, 1'b0}},
			'{OP_RD_BITS, 16'h0000, 1'b0, 1'b1, '{NO_BITS, 1'b0, 1'b0, 1'b0}},
			'{OP_RD_RX, 16'h0000, 1'b0, 1'b1, '0},
			'{OP_LINK_PULL, 16'h0000, 1'b1, 1'b1, '0},
			'{OP_SPARE_LO, 16'hffff, 1'b1, 1'b1, '0},
			'{OP_SPARE_HI, 16'hffff, 1'b1, 1'b1, '0},
			'{OP_WR_CSR, V_RX_EN | V_TX_EN, 1'b0, 1'b0, '0},
			'{OP_WR_TX, 16'hffff, 1'b0, 1'b0, '0},
			'{OP_WR_TX, 16'h0000, 1'b0, 1'b0, '0},
			'{OP_WR_TX, ADDR_AT_RESET, 1'b0, 1'b0, '0},
			'{OP_TRANSMIT, 16'h0000, 1'b0, 1'b0, '0},
			'{OP_LINK_PULL, 16'h0000, 1'b0, 1'b0, '0},
			'{OP_LINK_PULL, 16'h0000, 1'b0, 1'b0, '0},
			'{OP_LINK_PULL, 16'h0000, 1'b0, 1'b0, '0},
			'{OP_LINK_PULL, 16'h0000, 1'b0, 1'b0, '0},
			'{OP_LINK_PULL, 16'h0000, 1'b0, 1'b0, '0},
			'{OP_RD_BITS, 16'h0000, 1'b0, 1'b0, '0},
			'{OP_RD_RX, 16'h0000, 1'b0, 1'b0, '0},
			'{OP_LINK_RX, ADDR_AT_RESET, 1'b1, 1'b0, '0},
			'{OP_WR_CSR, 16'hffff, 1'b0, 1'b0, '0},
			'{OP_RD_CSR, 16'h0000, 1'b0, 1'b0, '0},
			'{OP_WR_CSR, V_RESET, 1'b0, 1'b0, '0},
			'{OP_WR_CSR, V_RX_CLR, 1'b0, 1'b0, '0},
			'{OP_RD_CSR, 16'h0000, 1'b0, 1'b0, '0}
		};
		foreach (rows[i]) begin
			rw = rows[i];
			issue(rw.opc, rw.wd, rw.lst, rw.known, rw.want);
		end

		// address at its low extreme; lost count driven to saturation
		write_station_address(16'h0000);
		issue(OP_WR_CSR, V_RX_CLR | V_RX_EN, 1'b0);
		issue(OP_LINK_RX, own_addr, 1'b0);
		issue(OP_LINK_RX, 16'($urandom), 1'b0);
		issue(OP_LINK_RX, 16'($urandom), 1'b1);
		for (int i = 0; i < 18; i++)
			issue(OP_LINK_RX, 16'($urandom), 1'b1);
		issue(OP_RD_CSR, 16'h0000, 1'b0);
		random_chunk(RANDOM_ITEMS / 4);

		// high extreme; transmit store filled past capacity and looped back
		write_station_address(16'hffff);
		issue(OP_WR_CSR, V_TX_CLR | V_LOOP | V_TX_EN, 1'b0);
		for (int i = 0; i < BUF_WORDS + 4; i++)
			issue(OP_WR_TX, 16'($urandom), 1'b0);
		send();
		issue(OP_RD_BITS, 16'h0000, 1'b0);
		for (int i = 0; i < 6; i++)
			issue(OP_RD_RX, 16'h0000, 1'b0);
		issue(OP_WR_CSR, V_RX_CLR, 1'b0);
		random_chunk(RANDOM_ITEMS / 4);

		// overlong link packet, then a mid-run pause until all responses are in
		write_station_address(16'($urandom));
		issue(OP_WR_CSR, V_RX_CLR | V_RX_EN, 1'b0);
		for (int i = 0; i < BUF_WORDS + 4; i++)
			issue(OP_LINK_RX, 16'($urandom), i == BUF_WORDS + 3);
		issue(OP_RD_CSR, 16'h0000, 1'b0);
		random_chunk(RANDOM_ITEMS / 8);
		drain();
		random_chunk(RANDOM_ITEMS / 8);

		write_station_address(ADDR_AT_RESET);
		random_chunk(RANDOM_ITEMS / 4);

		drain();
		repeat (SETTLE_CYCLES) @(negedge clk);
		$display("%0d requests issued, %0d responses checked, %0d packets transmitted",
			items, responses, sent_packets);
		$display("station address changed 4 times; %0d mismatches", errors);
		if (errors == 0 && expected_responses.size() == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

endmodule
